// File: rtl/tea_pkg.sv
// Types, constants and the round mixing function for the TEA block cipher.
// No dependencies; used by the interfaces and imported by all rtl modules.
`timescale 1ns / 1ps

package tea_pkg;

  localparam int WORD_W     = 32;
  localparam int RND_W      = 8;   // holds any round count up to 255
  localparam int ROUNDS_W   = 7;   // width of the round_count register
  localparam int CFG_IDX_W  = 3;

  localparam logic [WORD_W-1:0]   TEA_DELTA    = 32'h9E3779B9;
  localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 7'd32;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_ROUNDS = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [WORD_W-1:0] k0;
    logic [WORD_W-1:0] k1;
    logic [WORD_W-1:0] k2;
    logic [WORD_W-1:0] k3;
  } tea_key_t;

  // One block in flight, with everything a later stage needs.
  typedef struct packed {
    logic              mode;
    logic              last;
    logic [RND_W-1:0]  rounds;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
  } tea_item_t;

  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] x,
                                            input logic [WORD_W-1:0] sum,
                                            input logic [WORD_W-1:0] ka,
                                            input logic [WORD_W-1:0] kb);
    mix = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
  endfunction

endpackage

// File: rtl/tea_if.sv
// Valid/ready channel interfaces: block input, block result, config write.
// Depends on tea_pkg for widths.
`timescale 1ns / 1ps

interface tea_in_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [tea_pkg::WORD_W-1:0] text_low;
  logic [tea_pkg::WORD_W-1:0] text_high;
  logic                      last_block;

  modport source(output valid, mode, text_low, text_high, last_block, input ready);
  modport sink(input valid, mode, text_low, text_high, last_block, output ready);
endinterface

interface tea_out_if;
  logic                      valid;
  logic                      ready;
  logic [tea_pkg::WORD_W-1:0] result_low;
  logic [tea_pkg::WORD_W-1:0] result_high;
  logic                      result_last;

  modport source(output valid, result_low, result_high, result_last, input ready);
  modport sink(input valid, result_low, result_high, result_last, output ready);
endinterface

interface tea_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tea_pkg::CFG_IDX_W-1:0] index;
  logic [tea_pkg::WORD_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/tea_cfg_regs.sv
// Key and round count registers written through the config channel.
// Depends on tea_pkg and tea_cfg_if.
`timescale 1ns / 1ps

module tea_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  tea_cfg_if.sink                           cfg,
  output tea_pkg::tea_key_t                 key,
  output logic [tea_pkg::ROUNDS_W-1:0]      round_count
);
  import tea_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key         <= '0;
      round_count <= ROUNDS_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_KEY0:   key.k0 <= cfg.data;
        REG_KEY1:   key.k1 <= cfg.data;
        REG_KEY2:   key.k2 <= cfg.data;
        REG_KEY3:   key.k3 <= cfg.data;
        REG_ROUNDS: round_count <= cfg.data[ROUNDS_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

// File: rtl/tea_entry.sv
// Entry stage: clamps the round count and sets the starting sum per block.
// Depends on tea_pkg and tea_in_if.
`timescale 1ns / 1ps

module tea_entry #(
  parameter int MAX_ROUNDS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  tea_in_if.sink                        in_ch,
  input  logic [tea_pkg::ROUNDS_W-1:0]  round_count,
  output logic                          out_valid,
  output tea_pkg::tea_item_t            out_item
);
  import tea_pkg::*;

  localparam logic [RND_W-1:0] MAX_N = RND_W'(MAX_ROUNDS);

  logic [RND_W-1:0]  n_cfg;
  logic [RND_W-1:0]  n_eff;
  logic [WORD_W-1:0] dec_sum;
  tea_item_t         item_next;

  assign in_ch.ready = en;

  always_comb begin
    n_cfg   = RND_W'(round_count);
    n_eff   = (n_cfg > MAX_N) ? MAX_N : n_cfg;
    // decryption runs the sums backwards from delta * n
    dec_sum = WORD_W'(TEA_DELTA * WORD_W'(n_eff));
    item_next.mode   = in_ch.mode;
    item_next.last   = in_ch.last_block;
    item_next.rounds = n_eff;
    item_next.sum    = (in_ch.mode == MODE_DEC) ? dec_sum : '0;
    item_next.v0     = in_ch.text_low;
    item_next.v1     = in_ch.text_high;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

// File: rtl/tea_half_round.sv
// One half of a Feistel cycle: even stages update one word, odd the other.
// Depends on tea_pkg.
`timescale 1ns / 1ps

module tea_half_round #(
  parameter int STAGE = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  tea_pkg::tea_key_t  key,
  input  logic               in_valid,
  input  tea_pkg::tea_item_t in_item,
  output logic               out_valid,
  output tea_pkg::tea_item_t out_item
);
  import tea_pkg::*;

  localparam logic [RND_W-1:0] ROUND_IDX = RND_W'(STAGE / 2);
  localparam bit               ODD       = (STAGE % 2) == 1;

  logic              active;
  logic [WORD_W-1:0] sum_inc;
  tea_item_t         item_next;

  always_comb begin
    active    = in_item.rounds > ROUND_IDX;
    sum_inc   = in_item.sum + TEA_DELTA;
    item_next = in_item;
    if (active) begin
      if (in_item.mode == MODE_ENC) begin
        if (!ODD) begin
          item_next.sum = sum_inc;
          item_next.v0  = in_item.v0 + mix(in_item.v1, sum_inc, key.k0, key.k1);
        end else begin
          item_next.v1  = in_item.v1 + mix(in_item.v0, in_item.sum, key.k2, key.k3);
        end
      end else begin
        if (!ODD) begin
          item_next.v1  = in_item.v1 - mix(in_item.v0, in_item.sum, key.k2, key.k3);
        end else begin
          item_next.v0  = in_item.v0 - mix(in_item.v1, in_item.sum, key.k0, key.k1);
          item_next.sum = in_item.sum - TEA_DELTA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

// File: rtl/tea_block_cipher_top.sv
// TEA block cipher, ECB, fully pipelined: entry stage plus two stages per round.
// Depends on tea_pkg, tea_if, tea_cfg_regs, tea_entry, tea_half_round.
//
//   channel  dir  payload                                  done when
//   in_ch    in   mode, text_low, text_high, last_block    valid & ready
//   out_ch   out  result_low, result_high, result_last     valid & ready
//   cfg      in   index, data                              valid & ready
//
// Every block walks the whole pipe whatever round_count says: stages past
// its count pass it on. One block is taken per cycle while the pipe is not
// stalled; the pipe length is set by MAX_ROUNDS.
// A stalled result freezes the whole pipe, in_ch.ready then drops.
// Reset clears all valid bits, the key to zero and round_count to 32.
`timescale 1ns / 1ps

module tea_block_cipher_top #(
  parameter int MAX_ROUNDS = 64
) (
  input  logic       clk,
  input  logic       rst,
  tea_in_if.sink     in_ch,
  tea_out_if.source  out_ch,
  tea_cfg_if.sink    cfg
);
  import tea_pkg::*;

  localparam int NSTAGE = 2 * MAX_ROUNDS;

  tea_key_t               key;
  logic [ROUNDS_W-1:0]    round_count;
  logic                   en;
  logic [NSTAGE:0]        stage_valid;
  tea_item_t              stage_item [0:NSTAGE];

  assign en = !stage_valid[NSTAGE] || out_ch.ready;

  tea_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .key         (key),
    .round_count (round_count)
  );

  tea_entry #(.MAX_ROUNDS(MAX_ROUNDS)) u_entry (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_ch       (in_ch),
    .round_count (round_count),
    .out_valid   (stage_valid[0]),
    .out_item    (stage_item[0])
  );

  for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
    tea_half_round #(.STAGE(s)) u_half (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .key       (key),
      .in_valid  (stage_valid[s]),
      .in_item   (stage_item[s]),
      .out_valid (stage_valid[s+1]),
      .out_item  (stage_item[s+1])
    );
  end

  assign out_ch.valid       = stage_valid[NSTAGE];
  assign out_ch.result_low  = stage_item[NSTAGE].v0;
  assign out_ch.result_high = stage_item[NSTAGE].v1;
  assign out_ch.result_last = stage_item[NSTAGE].last;

  a_rounds_write: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && cfg.ready && cfg_reg_t'(cfg.index) == REG_ROUNDS
    |=> round_count == $past(cfg.data[ROUNDS_W-1:0]))
    else $error("round_count not updated by config request");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(stage_valid))
    else $error("pipeline moved while stalled");

  a_enc_start: assert property (@(posedge clk) disable iff (rst)
    stage_valid[0] && stage_item[0].mode == MODE_ENC |-> stage_item[0].sum == '0)
    else $error("encryption does not start from zero sum");

  a_round_clamp: assert property (@(posedge clk) disable iff (rst)
    stage_valid[0] |-> stage_item[0].rounds <= RND_W'(MAX_ROUNDS))
    else $error("round count above pipeline depth");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_ch.valid)
    else $error("result valid right after reset");

endmodule

// File: verif/tb.sv
// Self-checking bench for tea_block_cipher_top: drives blocks and key/round writes,
// predicts each result and checks it. Depends on tea_pkg, tea_if and tea_block_cipher_top.
`timescale 1ns / 1ps

module tb;
  import tea_pkg::*;

  localparam int MAX_ROUNDS   = 64;
  localparam int STALL_CYCLES = 600;
  localparam int SEG_ITEMS    = 175;

  typedef struct {
    logic              mode;
    logic [WORD_W-1:0] text_lo;
    logic [WORD_W-1:0] text_hi;
    logic              last;
  } block_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] res_lo;
    logic [WORD_W-1:0] res_hi;
    logic              res_last;
  } block_result_t;

  logic clk;
  logic rst;

  tea_in_if  in_ch();
  tea_out_if out_ch();
  tea_cfg_if cfg_ch();

  tea_block_cipher_top #(.MAX_ROUNDS(MAX_ROUNDS)) dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg   (cfg_ch)
  );

  block_req_t    queued_blocks[$];
  block_result_t pending_results[$];

  // Shadow of the block's registers
  tea_key_t            key_shadow;
  logic [ROUNDS_W-1:0] rounds_shadow;

  int send_idle_pct;
  int recv_idle_pct;
  int stall_req;
  int stall_seen;
  int stall_left;
  int errors;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] feistel_mix(input logic [WORD_W-1:0] x,
                                                    input logic [WORD_W-1:0] sum,
                                                    input logic [WORD_W-1:0] ka,
                                                    input logic [WORD_W-1:0] kb);
    feistel_mix = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
  endfunction

  function automatic block_result_t cipher_block(input logic mode,
                                                 input logic [WORD_W-1:0] lo,
                                                 input logic [WORD_W-1:0] hi,
                                                 input logic last);
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] sum;
    int n;
    n = (rounds_shadow > MAX_ROUNDS) ? MAX_ROUNDS : int'(rounds_shadow);
    v0 = lo;
    v1 = hi;
    if (mode == MODE_ENC) begin
      sum = '0;
      for (int i = 0; i < n; i++) begin
        sum = sum + TEA_DELTA;
        v0 = v0 + feistel_mix(v1, sum, key_shadow.k0, key_shadow.k1);
        v1 = v1 + feistel_mix(v0, sum, key_shadow.k2, key_shadow.k3);
      end
    end else begin
      sum = TEA_DELTA * WORD_W'(n);
      for (int i = 0; i < n; i++) begin
        v1 = v1 - feistel_mix(v0, sum, key_shadow.k2, key_shadow.k3);
        v0 = v0 - feistel_mix(v1, sum, key_shadow.k0, key_shadow.k1);
        sum = sum - TEA_DELTA;
      end
    end
    cipher_block = '{res_lo: v0, res_hi: v1, res_last: last};
  endfunction

  // Request driver
  always @(posedge clk) begin : block_driver
    block_req_t req;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (queued_blocks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req = queued_blocks.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= req.mode;
        in_ch.text_low   <= req.text_lo;
        in_ch.text_high  <= req.text_hi;
        in_ch.last_block <= req.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Predict on accepted request
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      pending_results.push_back(cipher_block(in_ch.mode, in_ch.text_low, in_ch.text_high,
                                             in_ch.last_block));
  end

  // Track register writes
  always @(posedge clk) begin
    if (!rst && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_KEY0:   key_shadow.k0 <= cfg_ch.data;
        REG_KEY1:   key_shadow.k1 <= cfg_ch.data;
        REG_KEY2:   key_shadow.k2 <= cfg_ch.data;
        REG_KEY3:   key_shadow.k3 <= cfg_ch.data;
        REG_ROUNDS: rounds_shadow <= cfg_ch.data[ROUNDS_W-1:0];
        default: ;
      endcase
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
      stall_seen   <= 0;
    end else if (stall_seen != stall_req) begin
      stall_seen   <= stall_req;
      stall_left   <= STALL_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin : result_checker
    block_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: low %h high %h last %b",
               out_ch.result_low, out_ch.result_high, out_ch.result_last);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.result_low !== want.res_lo) begin
          $error("result_low: expected %h, actual %h", want.res_lo, out_ch.result_low);
          errors++;
        end
        if (out_ch.result_high !== want.res_hi) begin
          $error("result_high: expected %h, actual %h", want.res_hi, out_ch.result_high);
          errors++;
        end
        if (out_ch.result_last !== want.res_last) begin
          $error("result_last: expected %b, actual %b", want.res_last, out_ch.result_last);
          errors++;
        end
      end
    end
  end

  task automatic queue_block(input logic mode, input logic [WORD_W-1:0] lo,
                             input logic [WORD_W-1:0] hi, input logic last);
    queued_blocks.push_back('{mode: mode, text_lo: lo, text_hi: hi, last: last});
  endtask

  // Sampled mid-cycle so a request popped at the last edge is already visible
  task automatic drain_blocks();
    while (queued_blocks.size() != 0 || pending_results.size() != 0 || in_ch.valid)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_rounds(input logic [WORD_W-1:0] value);
    drain_blocks();
    write_reg(REG_ROUNDS, value);
    @(posedge clk);
  endtask

  task automatic apply_config(input tea_key_t key, input logic [WORD_W-1:0] rounds);
    drain_blocks();
    write_reg(REG_KEY0, key.k0);
    write_reg(REG_KEY1, key.k1);
    write_reg(REG_KEY2, key.k2);
    write_reg(REG_KEY3, key.k3);
    set_rounds(rounds);
  endtask

  // Messages of 1..6 blocks, one direction each; most decrypts take real ciphertext
  task automatic queue_messages(input int count);
    block_req_t    req;
    block_result_t sealed;
    int            left;
    int            len;
    logic          dir;
    left = count;
    while (left > 0) begin
      len = $urandom_range(6, 1);
      if (len > left)
        len = left;
      dir = 1'($urandom_range(1));
      for (int b = 0; b < len; b++) begin
        req.mode    = dir;
        req.text_lo = $urandom;
        req.text_hi = $urandom;
        req.last    = (b == len - 1);
        if (dir == MODE_DEC && $urandom_range(9) < 7) begin
          sealed      = cipher_block(MODE_ENC, req.text_lo, req.text_hi, 1'b0);
          req.text_lo = sealed.res_lo;
          req.text_hi = sealed.res_hi;
        end
        if ($urandom_range(9) == 0)
          req.last = 1'($urandom_range(1));
        queued_blocks.push_back(req);
      end
      left -= len;
    end
  endtask

  initial begin : stimulus
    tea_key_t          key;
    logic [WORD_W-1:0] rounds_word;
    block_result_t     sealed;

    errors        = 0;
    stall_req     = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    key_shadow    = '0;
    rounds_shadow = ROUNDS_RESET;
    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_ENC;
    in_ch.text_low   = '0;
    in_ch.text_high  = '0;
    in_ch.last_block = 1'b0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_KEY0;
    cfg_ch.data      = '0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset config: zero key, 32 rounds
    queue_block(MODE_ENC, '0, '0, 1'b0);
    queue_block(MODE_ENC, '1, '1, 1'b1);
    queue_block(MODE_DEC, '0, '0, 1'b0);
    queue_block(MODE_DEC, '1, '1, 1'b1);

    apply_config('{k0: 32'h0123_4567, k1: 32'h89AB_CDEF, k2: 32'hFEDC_BA98,
                   k3: 32'h7654_3210}, 32);
    queue_block(MODE_ENC, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    queue_block(MODE_DEC, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    sealed = cipher_block(MODE_ENC, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    queue_block(MODE_DEC, sealed.res_lo, sealed.res_hi, 1'b1);

    // zero rounds pass through, single round, the maximum, and saturation
    set_rounds(0);
    queue_block(MODE_ENC, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1);
    queue_block(MODE_DEC, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0);
    set_rounds(1);
    queue_block(MODE_ENC, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0);
    queue_block(MODE_DEC, 32'h8000_0001, 32'h7FFF_FFFE, 1'b1);
    set_rounds(MAX_ROUNDS);
    queue_block(MODE_ENC, 32'hDEAD_BEEF, 32'h0BAD_F00D, 1'b0);
    queue_block(MODE_DEC, 32'hDEAD_BEEF, 32'h0BAD_F00D, 1'b1);
    set_rounds('1);
    queue_block(MODE_ENC, 32'hFFFF_0000, 32'h0000_FFFF, 1'b1);
    queue_block(MODE_DEC, 32'hFFFF_0000, 32'h0000_FFFF, 1'b0);

    // writes to unused indexes must be dropped; upper data bits of round count too
    drain_blocks();
    for (int i = REG_ROUNDS + 1; i < 2 ** CFG_IDX_W; i++)
      write_reg(CFG_IDX_W'(i), '1);
    set_rounds(32'h8000_0041);
    queue_block(MODE_ENC, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0);
    queue_block(MODE_DEC, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b1);

    for (int s = 0; s < 6; s++) begin
      key         = {$urandom, $urandom, $urandom, $urandom};
      rounds_word = 32;
      case (s)
        1, 5: rounds_word = $urandom;
        2: begin
          key         = '1;
          rounds_word = MAX_ROUNDS;
        end
        3: rounds_word = $urandom_range(16, 1);
        default: ;
      endcase
      apply_config(key, rounds_word);
      send_idle_pct = (s < 2) ? 19 : (s < 4) ? 88 : 0;
      recv_idle_pct = (s < 2) ? 88 : (s < 4) ? 19 : 0;
      queue_messages(SEG_ITEMS);
      // hold the output long enough that the pipe backs up into in_ch
      if (s == 4)
        stall_req++;
    end

    drain_blocks();
    repeat (2 * MAX_ROUNDS + 20) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: sim.f
rtl/tea_pkg.sv
rtl/tea_if.sv
rtl/tea_cfg_regs.sv
rtl/tea_entry.sv
rtl/tea_half_round.sv
rtl/tea_block_cipher_top.sv
verif/tb.sv
